/* src/rlld_pkg.sv */
`timescale 1ns / 1ps
package rlld_pkg;

    localparam int MAX_LINE_WIDTH = 768;
    localparam int HALF_LINE_WIDTH = MAX_LINE_WIDTH / 2;

    localparam int POS_W   = 10;
    localparam int BYTES_W = 11;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [BYTES_W-1:0] BYTES_SAT = {BYTES_W{1'b1}};

    // register index, taken from the word address
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_PAIR_MODE  = 1'b1;

    typedef struct packed {
        logic               awaiting_count;
        logic [7:0]         held_format;
        logic [POS_W-1:0]   source_position;
        logic [BYTES_W-1:0] bytes_taken;
    } line_state_t;

    typedef struct packed {
        logic [POS_W-1:0]   run_start;
        logic [6:0]         first_color;
        logic [2:0]         second_color;
        logic [POS_W-1:0]   run_length;
        logic               line_done;
        logic [BYTES_W-1:0] line_bytes;
    } run_t;

    typedef struct packed {
        logic [POS_W-1:0] line_width;
        logic             pair_mode;
        logic             restart;
    } cfg_t;

endpackage

/* src/run_length_line_decoder_unit.sv */
`timescale 1ns / 1ps
// run_valid rises once the byte that ends the run has passed the input byte register and
// then the result register; a stalled output holds it back. Format bytes that announce a
// count give no run.
// Throughput: one coded byte per cycle while the output is not stalled; the line state update
// is a single compare/add/clamp.
// Reset: line_width 768, pair_mode 0, line position, byte count and count expectation cleared,
// both pipeline stages empty. Any register write restarts the line.
module run_length_line_decoder_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rlld_pkg::ADDR_W-1:0]           paddr,
    input  logic [rlld_pkg::DATA_W-1:0]           pwdata,
    output logic [rlld_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  byte_valid,
    output logic                                  byte_stall,
    input  logic [7:0]                            data_byte,
    output logic                                  run_valid,
    input  logic                                  run_stall,
    output logic [rlld_pkg::POS_W-1:0]            run_start,
    output logic [6:0]                            first_color,
    output logic [2:0]                            second_color,
    output logic [rlld_pkg::POS_W-1:0]            run_length,
    output logic                                  line_done,
    output logic [rlld_pkg::BYTES_W-1:0]          line_bytes
);
    import rlld_pkg::*;

    cfg_t        cfg;
    line_state_t state_reg;
    line_state_t state_next;
    line_state_t dec_state;
    run_t        dec_run;
    run_t        run_reg;
    logic        dec_has_run;
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        run_valid_reg;
    logic        run_valid_next;
    logic        advance;
    logic        process;

    rlld_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlld_decode u_decode (
        .st      (state_reg),
        .data    (byte_reg),
        .cfg     (cfg),
        .st_next (dec_state),
        .has_run (dec_has_run),
        .run     (dec_run)
    );

    // pipeline moves whenever the result register is empty or being taken
    assign advance    = !run_valid_reg || !run_stall;
    assign byte_stall = byte_valid_reg && !advance;
    assign process    = byte_valid_reg && advance;

    always_comb
    begin
        state_next     = state_reg;
        run_valid_next = run_valid_reg;
        if (cfg.restart)
            state_next = '0;
        else if (process)
            state_next = dec_state;
        if (advance)
            run_valid_next = process && dec_has_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            run_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (!byte_stall)
                byte_valid_reg <= byte_valid;
            run_valid_reg <= run_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            byte_reg <= data_byte;
        if (advance)
            run_reg <= dec_run;
    end

    assign run_valid    = run_valid_reg;
    assign run_start    = run_reg.run_start;
    assign first_color  = run_reg.first_color;
    assign second_color = run_reg.second_color;
    assign run_length   = run_reg.run_length;
    assign line_done    = run_reg.line_done;
    assign line_bytes   = run_reg.line_bytes;

endmodule

/* src/rlld_cfg.sv */
`timescale 1ns / 1ps
module rlld_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rlld_pkg::ADDR_W-1:0] paddr,
    input  logic [rlld_pkg::DATA_W-1:0] pwdata,
    output logic [rlld_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rlld_pkg::cfg_t              cfg
);
    import rlld_pkg::*;

    logic [POS_W-1:0] line_width_reg;
    logic             pair_mode_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= POS_W'(MAX_LINE_WIDTH);
            pair_mode_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_LINE_WIDTH)
                line_width_reg <= pwdata[POS_W-1:0];
            else
                pair_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        if (reg_sel == REG_LINE_WIDTH)
            prdata = {{(DATA_W-POS_W){1'b0}}, line_width_reg};
        else
            prdata = {{(DATA_W-1){1'b0}}, pair_mode_reg};
    end

    // both registers restart the line when written
    assign cfg.line_width = line_width_reg;
    assign cfg.pair_mode  = pair_mode_reg;
    assign cfg.restart    = wr_en;

endmodule

/* src/rlld_decode.sv */
`timescale 1ns / 1ps
module rlld_decode (
    input  rlld_pkg::line_state_t st,
    input  logic [7:0]            data,
    input  rlld_pkg::cfg_t        cfg,
    output rlld_pkg::line_state_t st_next,
    output logic                  has_run,
    output rlld_pkg::run_t        run
);
    import rlld_pkg::*;

    logic [POS_W-1:0]   width;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   remaining;
    logic [BYTES_W-1:0] bytes_inc;
    logic [7:0]         format;
    logic               has_count;
    logic [POS_W-2:0]   pairs;
    logic [POS_W-1:0]   pair_len;
    logic [POS_W-1:0]   single_n;
    logic [POS_W-1:0]   len_src;
    logic               doubled;
    logic [POS_W:0]     pos_sum;
    logic               done;

    always_comb
    begin
        if (cfg.line_width == '0)
            width = POS_W'(1);
        else if (cfg.line_width > POS_W'(MAX_LINE_WIDTH))
            width = POS_W'(MAX_LINE_WIDTH);
        else
            width = cfg.line_width;

        pos       = st.source_position;
        remaining = (pos < width) ? width - pos : '0;
        bytes_inc = (st.bytes_taken == BYTES_SAT) ? st.bytes_taken : st.bytes_taken + 1'b1;

        has_count = st.awaiting_count;
        format    = st.awaiting_count ? st.held_format : data;

        // pair mode: count in pixel pairs, zero pairs becomes one pair
        if (!has_count)
            pairs = (POS_W-1)'(1);
        else if (data == 8'd0)
            pairs = remaining[POS_W-1:1];
        else
            pairs = (POS_W-1)'(data);
        if (pairs == '0)
            pairs = (POS_W-1)'(1);
        pair_len = {pairs, 1'b0};

        if (!has_count)
            single_n = POS_W'(1);
        else if (data == 8'd0)
            single_n = remaining;
        else
            single_n = POS_W'(data);

        if (cfg.pair_mode)
            len_src = (pair_len > remaining) ? remaining : pair_len;
        else
            len_src = (single_n > remaining) ? remaining : single_n;

        doubled = !cfg.pair_mode && (width <= POS_W'(HALF_LINE_WIDTH));
        pos_sum = {1'b0, pos} + {1'b0, len_src};
        done    = pos_sum >= {1'b0, width};

        run.run_start    = doubled ? {pos[POS_W-2:0], 1'b0} : pos;
        run.run_length   = doubled ? {len_src[POS_W-2:0], 1'b0} : len_src;
        run.first_color  = cfg.pair_mode ? {4'd0, format[6:4]} : format[6:0];
        run.second_color = cfg.pair_mode ? format[2:0] : 3'd0;
        run.line_done    = done;
        run.line_bytes   = done ? bytes_inc : '0;

        st_next = st;
        st_next.bytes_taken = bytes_inc;
        has_run = 1'b0;
        if (!st.awaiting_count && data[7])
        begin
            // format byte announcing a count byte
            st_next.held_format    = data;
            st_next.awaiting_count = 1'b1;
        end
        else
        begin
            has_run                = 1'b1;
            st_next.awaiting_count = 1'b0;
            if (done)
            begin
                st_next.source_position = '0;
                st_next.bytes_taken     = '0;
            end
            else
                st_next.source_position = pos_sum[POS_W-1:0];
        end
    end

endmodule

/* src/rlld_checker.sv */
`timescale 1ns / 1ps
module rlld_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          run_valid,
    input logic                          run_stall,
    input logic [rlld_pkg::POS_W-1:0]    run_start,
    input logic [6:0]                    first_color,
    input logic [2:0]                    second_color,
    input logic [rlld_pkg::POS_W-1:0]    run_length,
    input logic                          line_done,
    input logic [rlld_pkg::BYTES_W-1:0]  line_bytes
);
    import rlld_pkg::*;

    // a stalled run holds until transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_start) && $stable(run_length)
            && $stable(first_color) && $stable(second_color) && $stable(line_done)
            && $stable(line_bytes))
        else $error("stalled run changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !line_done |-> line_bytes == '0)
        else $error("byte count reported before line end");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> run_length != '0)
        else $error("empty run");

    // runs never pass the end of the destination line
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> ({1'b0, run_start} + {1'b0, run_length}) <= (POS_W+1)'(MAX_LINE_WIDTH))
        else $error("run passes line end");

endmodule

bind run_length_line_decoder_unit rlld_checker u_rlld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_valid    (run_valid),
    .run_stall    (run_stall),
    .run_start    (run_start),
    .first_color  (first_color),
    .second_color (second_color),
    .run_length   (run_length),
    .line_done    (line_done),
    .line_bytes   (line_bytes)
);

/* dv/tb_run_length_line_decoder_unit.sv */
`timescale 1ns / 1ps
module tb_run_length_line_decoder_unit;
    import rlld_pkg::*;

    // Predicts the runs of the line decoder and checks the block's runs against them.
    class rl_line_checker;
        logic [POS_W-1:0] width_reg;
        logic             pair_reg;
        logic             count_pending;
        logic [7:0]       format_byte;
        int unsigned      src_pos;
        int unsigned      bytes_in_line;
        run_t             expected_runs[$];
        int               fail_count;

        function new();
            width_reg  = POS_W'(MAX_LINE_WIDTH);
            pair_reg   = 1'b0;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            count_pending = 1'b0;
            format_byte   = 8'h00;
            src_pos       = 0;
            bytes_in_line = 0;
        endfunction

        function void write_reg(logic idx, logic [DATA_W-1:0] value);
            if (idx == REG_LINE_WIDTH)
                width_reg = value[POS_W-1:0];
            else
                pair_reg = value[0];
            restart();
        endfunction

        function void decode_run(logic [7:0] fmt, bit has_count, logic [7:0] cnt);
            int unsigned w;
            int unsigned remaining;
            int unsigned n;
            int unsigned len_src;
            int unsigned len_dst;
            int unsigned start;
            int unsigned scale;
            run_t r;
            w = width_reg;
            if (w < 1)
                w = 1;
            if (w > MAX_LINE_WIDTH)
                w = MAX_LINE_WIDTH;
            remaining = (src_pos < w) ? w - src_pos : 0;
            if (pair_reg)
            begin
                n = 1;
                if (has_count)
                    n = (cnt == 0) ? remaining >> 1 : cnt;
                if (n == 0)
                    n = 1;
                len_src = n * 2;
                if (len_src > remaining)
                    len_src = remaining;
                start = src_pos;
                len_dst = len_src;
                r.first_color  = {4'b0000, fmt[6:4]};
                r.second_color = fmt[2:0];
            end
            else
            begin
                // doubled pixels when the line is at most half the maximum width
                scale = (2 * w <= MAX_LINE_WIDTH) ? 2 : 1;
                n = 1;
                if (has_count)
                    n = (cnt == 0) ? remaining : cnt;
                len_src = (n > remaining) ? remaining : n;
                start = src_pos * scale;
                len_dst = len_src * scale;
                r.first_color  = fmt[6:0];
                r.second_color = 3'd0;
            end
            src_pos += len_src;
            r.run_start  = start[POS_W-1:0];
            r.run_length = len_dst[POS_W-1:0];
            if (src_pos >= w)
            begin
                r.line_done   = 1'b1;
                r.line_bytes  = bytes_in_line[BYTES_W-1:0];
                src_pos       = 0;
                bytes_in_line = 0;
            end
            else
            begin
                r.line_done  = 1'b0;
                r.line_bytes = '0;
            end
            expected_runs.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            if (bytes_in_line < BYTES_SAT)
                bytes_in_line++;
            if (count_pending)
            begin
                count_pending = 1'b0;
                decode_run(format_byte, 1'b1, b);
            end
            else if (b[7])
            begin
                format_byte   = b;
                count_pending = 1'b1;
            end
            else
                decode_run(b, 1'b0, 8'h00);
        endfunction

        function void check_run(run_t got);
            run_t exp;
            bit   bad;
            if (expected_runs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected run: start %0d c1 %0d c2 %0d len %0d done %0d bytes %0d",
                             got.run_start, got.first_color, got.second_color,
                             got.run_length, got.line_done, got.line_bytes);
                return;
            end
            exp = expected_runs.pop_front();
            bad = (got.run_start    !== exp.run_start)    ||
                  (got.first_color  !== exp.first_color)  ||
                  (got.second_color !== exp.second_color) ||
                  (got.run_length   !== exp.run_length)   ||
                  (got.line_done    !== exp.line_done)    ||
                  (got.line_bytes   !== exp.line_bytes);
            if (bad)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"run mismatch: exp start %0d c1 %0d c2 %0d len %0d done %0d ",
                              "bytes %0d / got start %0d c1 %0d c2 %0d len %0d done %0d ",
                              "bytes %0d"},
                             exp.run_start, exp.first_color, exp.second_color,
                             exp.run_length, exp.line_done, exp.line_bytes,
                             got.run_start, got.first_color, got.second_color,
                             got.run_length, got.line_done, got.line_bytes);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                byte_valid;
    logic                byte_stall;
    logic [7:0]          data_byte;
    logic                run_valid;
    logic                run_stall;
    logic [POS_W-1:0]    run_start;
    logic [6:0]          first_color;
    logic [2:0]          second_color;
    logic [POS_W-1:0]    run_length;
    logic                line_done;
    logic [BYTES_W-1:0]  line_bytes;

    rl_line_checker checker_h;
    int             burst_left;
    int             hold_left;
    int             stall_style;
    int             style_left;
    int             stall_tick;

    run_length_line_decoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .run_valid    (run_valid),
        .run_stall    (run_stall),
        .run_start    (run_start),
        .first_color  (first_color),
        .second_color (second_color),
        .run_length   (run_length),
        .line_done    (line_done),
        .line_bytes   (line_bytes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // run receiver: long hold-off on request, else alternating stall patterns
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            run_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 200);
            end
            style_left--;
            stall_tick++;
            case (stall_style)
                0:       run_stall <= 1'b0;
                1:       run_stall <= ($urandom_range(0, 99) < 40);
                default: run_stall <= (stall_tick % 3 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && run_valid && !run_stall)
            checker_h.check_run({run_start, first_color, second_color,
                                 run_length, line_done, line_bytes});
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        data_byte  <= b;
        do @(posedge clk); while (byte_stall);
        checker_h.take_byte(b);
    endtask

    // drain all runs; extra cycles cover a count-announcing byte still in flight
    task automatic wait_idle();
        int n;
        byte_valid <= 1'b0;
        n = 0;
        while (checker_h.expected_runs.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        checker_h.write_reg(idx, value);
    endtask

    task automatic configure(int width, int pair);
        write_reg(REG_LINE_WIDTH, DATA_W'(width));
        write_reg(REG_PAIR_MODE, DATA_W'(pair));
    endtask

    // mostly well-formed runs with random content, some stray bytes
    task automatic send_random_run(ref int sent);
        int         pick;
        int         cpick;
        logic [7:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            cpick = $urandom_range(0, 9);
            if (cpick == 0)
                cnt = 8'h00;
            else if (cpick < 5)
                cnt = 8'($urandom_range(1, 8));
            else
                cnt = 8'($urandom_range(0, 255));
            send_byte(8'h80 | 8'($urandom_range(0, 127)));
            send_byte(cnt);
            sent += 2;
        end
        else if (pick < 90)
        begin
            send_byte(8'($urandom_range(0, 127)));
            sent++;
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    initial
    begin
        int widths[12];
        int pairs[12];
        int sent;
        checker_h   = new();
        burst_left  = 0;
        hold_left   = 0;
        stall_style = 0;
        style_left  = 0;
        stall_tick  = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        byte_valid  = 1'b0;
        data_byte   = 8'h00;
        run_stall   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: full width, single pixels, no doubling
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h85);
        send_byte(8'h00);
        wait_idle();
        // doubled width, run clamped at line end, count left pending at write
        write_reg(REG_LINE_WIDTH, 384);
        send_byte(8'h2A);
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h90);
        wait_idle();
        write_reg(REG_PAIR_MODE, 1);
        send_byte(8'h77);
        send_byte(8'h8F);
        send_byte(8'h00);
        send_byte(8'hF0);
        send_byte(8'h03);
        wait_idle();
        // single-pixel line in pair mode: zero pairs become one, clamped to one pixel
        write_reg(REG_LINE_WIDTH, 1);
        send_byte(8'h12);
        send_byte(8'h80);
        send_byte(8'h00);
        wait_idle();
        configure(0, 0);
        send_byte(8'h05);
        wait_idle();
        configure(1023, 0);
        send_byte(8'h83);
        send_byte(8'h00);
        wait_idle();

        widths = '{768, 360, 384, 720, 1023, 0, 1, 5, 384, 768, 17, 720};
        pairs  = '{0, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 0};
        for (int p = 0; p < 12; p++)
        begin
            configure(widths[p], pairs[p]);
            sent = 0;
            if (p == 3)
                hold_left = 300;
            while (sent < 45)
                send_random_run(sent);
            wait_idle();
        end

        if (checker_h.expected_runs.size() != 0)
            checker_h.fail_count += checker_h.expected_runs.size();
        if (checker_h.fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
